// ===== hdl/pcss_pkg.sv =====
// Shared types, constants and helper functions for the per-channel statistics block.
package pcss_pkg;

  localparam int CHANNELS   = 8;
  localparam int CODE_BITS  = 12;
  localparam int COUNT_BITS = 20;

  localparam int CHAN_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W   = CODE_BITS + COUNT_BITS;
  localparam int SQ_W    = 2 * CODE_BITS + COUNT_BITS;
  localparam int DIV_W   = SQ_W + 8;
  localparam int ROOT_W  = (DIV_W + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int FRAC_W  = 16;

  localparam int THR_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_OVER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDER = 1'b1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [CODE_BITS-1:0]  CODE_MAX  = {CODE_BITS{1'b1}};

  typedef struct packed {
    logic        req_type;
    logic [7:0]  chan_id;
    logic [11:0] sample_code;
    logic        sensor_fault;
    logic        range_flag;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  report_chan;
    logic [19:0] total_samples;
    logic [19:0] over_hits;
    logic [19:0] under_hits;
    logic [19:0] fault_hits;
    logic [19:0] range_hits;
    logic [15:0] mean_value;
    logic [11:0] min_value;
    logic [11:0] max_value;
    logic [15:0] rms_value;
    logic [15:0] std_value;
    logic        last_row;
  } out_beat_t;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  // One channel's entry in the statistics store.
  typedef struct packed {
    logic [COUNT_BITS-1:0] sample_tally;
    logic [COUNT_BITS-1:0] over_tally;
    logic [COUNT_BITS-1:0] under_tally;
    logic [COUNT_BITS-1:0] fault_tally;
    logic [COUNT_BITS-1:0] range_tally;
    logic [SUM_W-1:0]      code_sum;
    logic [SQ_W-1:0]       square_sum;
    logic [CODE_BITS-1:0]  least_code;
    logic [CODE_BITS-1:0]  greatest_code;
  } rec_t;

  localparam rec_t REC_RESET = '{
    sample_tally:  '0,
    over_tally:    '0,
    under_tally:   '0,
    fault_tally:   '0,
    range_tally:   '0,
    code_sum:      '0,
    square_sum:    '0,
    least_code:    CODE_MAX,
    greatest_code: '0
  };

  typedef struct packed {
    logic                  vld;
    logic [CHAN_W-1:0]     chan;
    logic [CODE_BITS-1:0]  code;
    logic                  fault;
    logic                  range_hit;
  } smp_t;

  typedef struct packed {
    logic                  go;
    logic [DIV_W-1:0]      num;
    logic [COUNT_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_W-1:0]      quo;
    logic [COUNT_BITS-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             go;
    logic [RAD_W-1:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] sat16(input logic [DIV_W-1:0] v);
    return (v > DIV_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ===== hdl/per_channel_sample_statistics_top.sv =====
// Per-channel sample statistics: top level with the report sequencer.
//
// Samples are taken one per cycle while no report runs: each one is a single
// read-modify-write of an eight-entry channel memory, with a bypass for
// back-to-back samples on the same channel, and samples tagged with a channel
// at or above the channel count are dropped. A report request blocks the input
// and produces one row per channel in channel order; each non-empty row is
// computed on the one shared bit-serial divider and the bit-serial square root
// unit, and each row waits on out_ready. After the last row the store is
// cleared through per-entry valid bits, so there is no clearing pass after
// reset. The thresholds are written through the cfg port; the user must write
// them only while the block is idle, as the block itself does not enforce it.
module per_channel_sample_statistics_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pcss_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pcss_pkg::out_beat_t               out_data,
  input  logic                              cfg_we,
  input  logic [pcss_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pcss_pkg::THR_W-1:0]        cfg_wdata
);
  import pcss_pkg::*;

  typedef enum logic [2:0] {
    T_RUN, T_RD, T_LOAD, T_CALC, T_SEND
  } top_st_t;

  top_st_t           st_r;
  logic [CHAN_W-1:0] row_r;
  logic [THR_W-1:0]  over_thr_r;
  logic [THR_W-1:0]  under_thr_r;
  logic              out_valid_r;
  out_beat_t         out_r;
  rec_t              row_rec_r;
  logic              stats_go_r;
  logic              clear_r;

  logic              in_fire;
  smp_t              smp;
  logic [CHAN_W-1:0] rd_addr;
  rec_t              rd_rec;
  logic              stats_done;
  logic [15:0]       mean_v;
  logic [15:0]       rms_v;
  logic [15:0]       std_v;
  logic              empty;

  assign in_ready = (st_r == T_RUN);
  assign in_fire  = in_valid && in_ready;

  assign smp.vld       = in_fire && (in_data.req_type == REQ_SAMPLE) &&
                         (in_data.chan_id < 8'(CHANNELS));
  assign smp.chan      = CHAN_W'(in_data.chan_id);
  assign smp.code      = CODE_BITS'(in_data.sample_code);
  assign smp.fault     = in_data.sensor_fault;
  assign smp.range_hit = in_data.range_flag;

  assign rd_addr = (st_r == T_RUN) ? CHAN_W'(in_data.chan_id) : row_r;

  pcss_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp       (smp),
    .rd_addr   (rd_addr),
    .over_thr  (over_thr_r),
    .under_thr (under_thr_r),
    .clear_all (clear_r),
    .rd_rec    (rd_rec)
  );

  pcss_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (stats_go_r),
    .rec        (row_rec_r),
    .done       (stats_done),
    .mean_value (mean_v),
    .rms_value  (rms_v),
    .std_value  (std_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      over_thr_r  <= THR_W'(4095);
      under_thr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_OVER:  over_thr_r  <= cfg_wdata;
        CFG_UNDER: under_thr_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  assign empty = (row_rec_r.sample_tally == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_RUN;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      stats_go_r  <= 1'b0;
      clear_r     <= 1'b0;
    end else begin
      stats_go_r <= 1'b0;
      clear_r    <= 1'b0;
      unique case (st_r)
        T_RUN: begin
          if (in_fire && (in_data.req_type == REQ_REPORT)) begin
            row_r <= '0;
            st_r  <= T_RD;
          end
        end
        T_RD: st_r <= T_LOAD;
        T_LOAD: begin
          row_rec_r  <= rd_rec;
          stats_go_r <= 1'b1;
          st_r       <= T_CALC;
        end
        T_CALC: begin
          if (stats_done) begin
            out_r.report_chan   <= 3'(row_r);
            out_r.total_samples <= row_rec_r.sample_tally;
            out_r.over_hits     <= row_rec_r.over_tally;
            out_r.under_hits    <= row_rec_r.under_tally;
            out_r.fault_hits    <= row_rec_r.fault_tally;
            out_r.range_hits    <= row_rec_r.range_tally;
            out_r.mean_value    <= mean_v;
            out_r.min_value     <= empty ? '0 : 12'(row_rec_r.least_code);
            out_r.max_value     <= empty ? '0 : 12'(row_rec_r.greatest_code);
            out_r.rms_value     <= rms_v;
            out_r.std_value     <= std_v;
            out_r.last_row      <= (row_r == CHAN_W'(CHANNELS - 1));
            out_valid_r         <= 1'b1;
            st_r                <= T_SEND;
          end
        end
        T_SEND: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (row_r == CHAN_W'(CHANNELS - 1)) begin
              clear_r <= 1'b1;
              st_r    <= T_RUN;
            end else begin
              row_r <= row_r + 1'b1;
              st_r  <= T_RD;
            end
          end
        end
        default: st_r <= T_RUN;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/pcss_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
module pcss_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pcss_pkg::div_req_t req,
  output pcss_pkg::div_rsp_t rsp
);
  import pcss_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]      num_r;
  logic [COUNT_BITS-1:0] den_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;
  logic [COUNT_BITS-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, num_r[DIV_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r <= {num_r[DIV_W-2:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== hdl/pcss_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
module pcss_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  pcss_pkg::sqrt_req_t req,
  output pcss_pkg::sqrt_rsp_t rsp
);
  import pcss_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W+1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [ROOT_W+3:0] t;
  logic [ROOT_W+3:0] trial;
  logic [ROOT_W+3:0] diff;
  logic              ge;

  always_comb begin
    t     = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial = (ROOT_W + 4)'({root_r, 2'b01});
    diff  = t - trial;
    ge    = (t >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        rad_r  <= req.rad;
        root_r <= '0;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        root_r <= {root_r[ROOT_W-2:0], ge};
        rem_r  <= ge ? diff[ROOT_W+1:0] : t[ROOT_W+1:0];
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

// ===== hdl/pcss_store.sv =====
// Channel statistics memory with its read-modify-write sample update path.
module pcss_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pcss_pkg::smp_t                  smp,
  input  logic [pcss_pkg::CHAN_W-1:0]     rd_addr,
  input  logic [pcss_pkg::THR_W-1:0]      over_thr,
  input  logic [pcss_pkg::THR_W-1:0]      under_thr,
  input  logic                            clear_all,
  output pcss_pkg::rec_t                  rd_rec
);
  import pcss_pkg::*;

  rec_t                   mem [CHANNELS];
  logic [CHANNELS-1:0]    valid_r;

  logic                   s1_vld_r;
  logic [CHAN_W-1:0]      s1_chan_r;
  logic [CODE_BITS-1:0]   s1_code_r;
  logic [2*CODE_BITS-1:0] s1_sq_r;
  logic                   s1_fault_r;
  logic                   s1_range_r;

  rec_t                   rd_q_r;
  logic                   rd_vld_r;
  logic                   fwd_hit_r;
  rec_t                   fwd_rec_r;

  rec_t                   cur;
  rec_t                   rec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      s1_vld_r  <= smp.vld;
      fwd_hit_r <= s1_vld_r && (s1_chan_r == rd_addr);
    end
    s1_chan_r  <= smp.chan;
    s1_code_r  <= smp.code;
    s1_sq_r    <= smp.code * smp.code;
    s1_fault_r <= smp.fault;
    s1_range_r <= smp.range_hit;
    fwd_rec_r  <= rec_nxt;
  end

  // An entry written in the cycle it is read is taken from the bypass register.
  always_comb begin
    if (fwd_hit_r) begin
      cur = fwd_rec_r;
    end else if (rd_vld_r) begin
      cur = rd_q_r;
    end else begin
      cur = REC_RESET;
    end
  end

  always_comb begin
    rec_nxt = cur;
    if (cur.sample_tally != COUNT_MAX) begin
      rec_nxt.sample_tally = cur.sample_tally + 1'b1;
      rec_nxt.code_sum     = cur.code_sum + SUM_W'(s1_code_r);
      rec_nxt.square_sum   = cur.square_sum + SQ_W'(s1_sq_r);
      if (s1_code_r < cur.least_code) begin
        rec_nxt.least_code = s1_code_r;
      end
      if (s1_code_r > cur.greatest_code) begin
        rec_nxt.greatest_code = s1_code_r;
      end
    end
    if (s1_code_r > over_thr) begin
      rec_nxt.over_tally = sat_inc(cur.over_tally);
    end
    if (s1_code_r < under_thr) begin
      rec_nxt.under_tally = sat_inc(cur.under_tally);
    end
    if (s1_fault_r) begin
      rec_nxt.fault_tally = sat_inc(cur.fault_tally);
    end
    if (s1_range_r) begin
      rec_nxt.range_tally = sat_inc(cur.range_tally);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      mem[s1_chan_r] <= rec_nxt;
    end
    rd_q_r <= mem[rd_addr];
  end

  // A read in the clearing cycle must already see the entry as empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[rd_addr] && !clear_all;
      if (clear_all) begin
        valid_r <= '0;
      end else if (s1_vld_r) begin
        valid_r[s1_chan_r] <= 1'b1;
      end
    end
  end

  assign rd_rec = cur;

endmodule

// ===== hdl/pcss_stats.sv =====
// Report arithmetic: mean, RMS and standard deviation of one channel entry.
module pcss_stats (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pcss_pkg::rec_t      rec,
  output logic                done,
  output logic [15:0]         mean_value,
  output logic [15:0]         rms_value,
  output logic [15:0]         std_value
);
  import pcss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MEAN, S_QR, S_MQQ, S_MSUB, S_A1, S_A2, S_VDIV,
    S_FDIV, S_FRAC, S_VSUB, S_VSQ, S_RDIV, S_RSQ
  } st_t;

  st_t                       st_r;
  logic                      div_go_r;
  logic [DIV_W-1:0]          div_num_r;
  logic                      sq_go_r;
  logic [RAD_W-1:0]          sq_rad_r;
  logic                      done_r;

  logic [SUM_W-1:0]          s_r;
  logic [SQ_W-1:0]           s2_r;
  logic [COUNT_BITS-1:0]     n_r;
  logic [CODE_BITS-1:0]      q_r;
  logic [COUNT_BITS-1:0]     r_r;
  logic [2*CODE_BITS-1:0]    qq_r;
  logic [SQ_W-1:0]           sub1_r;
  logic [SQ_W-1:0]           sub2_r;
  logic [SQ_W-1:0]           a_r;
  logic [DIV_W-1:0]          v_r;
  logic [FRAC_W-1:0]         f_r;
  logic [7:0]                frac_r;
  logic [15:0]               mean_r;
  logic [15:0]               rms_r;
  logic [15:0]               std_r;

  logic [SQ_W-1:0]           a2;
  logic [2*FRAC_W-1:0]       ff;
  logic [SUM_W-1:0]          qr;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  sqrt_req_t                 sq_req;
  sqrt_rsp_t                 sq_rsp;

  assign div_req.go  = div_go_r;
  assign div_req.num = div_num_r;
  assign div_req.den = n_r;
  assign sq_req.go   = sq_go_r;
  assign sq_req.rad  = sq_rad_r;

  pcss_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  pcss_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));

  always_comb begin
    a2 = (a_r > sub2_r) ? a_r - sub2_r : '0;
    ff = f_r * f_r;
    qr = SUM_W'(q_r) * SUM_W'(r_r);
  end

  // The variance is the sum of squares less n*q*q and 2*q*r (q and r the quotient
  // and remainder), over n, with the mean's fraction squared and removed last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      div_go_r <= 1'b0;
      sq_go_r  <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      sq_go_r  <= 1'b0;
      done_r   <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            s_r  <= rec.code_sum;
            s2_r <= rec.square_sum;
            n_r  <= rec.sample_tally;
            if (rec.sample_tally == '0) begin
              mean_r <= '0;
              rms_r  <= '0;
              std_r  <= '0;
              done_r <= 1'b1;
            end else begin
              div_num_r <= DIV_W'({rec.code_sum, 4'b0000});
              div_go_r  <= 1'b1;
              st_r      <= S_MEAN;
            end
          end
        end
        S_MEAN: begin
          if (div_rsp.done) begin
            mean_r    <= sat16(div_rsp.quo);
            div_num_r <= DIV_W'(s_r);
            div_go_r  <= 1'b1;
            st_r      <= S_QR;
          end
        end
        S_QR: begin
          if (div_rsp.done) begin
            q_r  <= div_rsp.quo[CODE_BITS-1:0];
            r_r  <= div_rsp.rem;
            st_r <= S_MQQ;
          end
        end
        S_MQQ: begin
          qq_r <= q_r * q_r;
          st_r <= S_MSUB;
        end
        S_MSUB: begin
          sub1_r <= qq_r * n_r;
          sub2_r <= SQ_W'({qr, 1'b0});
          st_r   <= S_A1;
        end
        S_A1: begin
          a_r  <= (s2_r > sub1_r) ? s2_r - sub1_r : '0;
          st_r <= S_A2;
        end
        S_A2: begin
          div_num_r <= DIV_W'({a2, 8'h00});
          div_go_r  <= 1'b1;
          st_r      <= S_VDIV;
        end
        S_VDIV: begin
          if (div_rsp.done) begin
            v_r       <= div_rsp.quo;
            div_num_r <= DIV_W'({r_r, 16'h0000});
            div_go_r  <= 1'b1;
            st_r      <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_rsp.done) begin
            f_r  <= div_rsp.quo[FRAC_W-1:0];
            st_r <= S_FRAC;
          end
        end
        S_FRAC: begin
          frac_r <= ff[2*FRAC_W-1 -: 8];
          st_r   <= S_VSUB;
        end
        S_VSUB: begin
          sq_rad_r <= (v_r > DIV_W'(frac_r)) ? RAD_W'(v_r - DIV_W'(frac_r)) : '0;
          sq_go_r  <= 1'b1;
          st_r     <= S_VSQ;
        end
        S_VSQ: begin
          if (sq_rsp.done) begin
            std_r     <= sat16(DIV_W'(sq_rsp.root));
            div_num_r <= DIV_W'({s2_r, 8'h00});
            div_go_r  <= 1'b1;
            st_r      <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_rsp.done) begin
            sq_rad_r <= RAD_W'(div_rsp.quo);
            sq_go_r  <= 1'b1;
            st_r     <= S_RSQ;
          end
        end
        S_RSQ: begin
          if (sq_rsp.done) begin
            rms_r  <= sat16(DIV_W'(sq_rsp.root));
            done_r <= 1'b1;
            st_r   <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done       = done_r;
  assign mean_value = mean_r;
  assign rms_value  = rms_r;
  assign std_value  = std_r;

endmodule

// ===== hdl/pcss_checker.sv =====
// Port-level checks for the statistics block, bound to its top level.
module pcss_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pcss_pkg::out_beat_t out_data
);
  import pcss_pkg::*;

  // A result beat that is held back keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Input stays closed while a report is being delivered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input open during a report");

  // Every row needs fresh arithmetic, so rows never follow back to back.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("report rows issued back to back");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_row |-> out_data.report_chan == 3'(CHANNELS - 1))
    else $error("last row flag on the wrong channel");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.total_samples == '0) |->
      (out_data.mean_value == '0) && (out_data.min_value == '0) &&
      (out_data.max_value == '0) && (out_data.std_value == '0))
    else $error("empty channel row carries statistics");

endmodule

bind per_channel_sample_statistics_top pcss_checker u_pcss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the per-channel sample statistics block.
`timescale 1ns / 1ps

module testbench;
  import pcss_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_OVER;
  logic [THR_W-1:0]     cfg_wdata = '0;

  per_channel_sample_statistics_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Shadow of the statistics store and thresholds.
  longint unsigned n_seen[CHANNELS], n_over[CHANNELS], n_under[CHANNELS];
  longint unsigned n_fault[CHANNELS], n_range[CHANNELS];
  longint unsigned code_total[CHANNELS], square_total[CHANNELS];
  longint unsigned code_low[CHANNELS], code_high[CHANNELS];
  longint unsigned over_lim = 4095, under_lim = 0;

  out_beat_t pending_rows[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned rows_seen = 0;
  logic        hold_off = 1'b0;
  event        hold_ev;

  function automatic longint unsigned bump(longint unsigned v);
    return (v < longint'(COUNT_MAX)) ? v + 1 : v;
  endfunction

  function automatic longint unsigned div_shift(longint unsigned a, longint unsigned n,
                                                int sh);
    return ((a / n) << sh) + (((a % n) << sh) / n);
  endfunction

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      b = r | (64'd1 << k);
      if (b * b <= x) r = b;
    end
    return r;
  endfunction

  function automatic logic [15:0] clip16(longint unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic clear_shadow();
    for (int c = 0; c < CHANNELS; c++) begin
      n_seen[c] = 0; n_over[c] = 0; n_under[c] = 0; n_fault[c] = 0; n_range[c] = 0;
      code_total[c] = 0; square_total[c] = 0; code_low[c] = 4095; code_high[c] = 0;
    end
  endtask

  task automatic predict_beat(in_beat_t b);
    longint unsigned code, n, s, s2, q, r, a, v, f, frac;
    int ch;
    out_beat_t row;
    if (b.req_type == REQ_SAMPLE) begin
      if (b.chan_id >= CHANNELS) return;
      ch = b.chan_id;
      code = b.sample_code;
      if (n_seen[ch] < longint'(COUNT_MAX)) begin
        n_seen[ch]++;
        code_total[ch] += code;
        square_total[ch] += code * code;
        if (code < code_low[ch]) code_low[ch] = code;
        if (code > code_high[ch]) code_high[ch] = code;
      end
      if (code > over_lim) n_over[ch] = bump(n_over[ch]);
      if (code < under_lim) n_under[ch] = bump(n_under[ch]);
      if (b.sensor_fault) n_fault[ch] = bump(n_fault[ch]);
      if (b.range_flag) n_range[ch] = bump(n_range[ch]);
      return;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      row = '0;
      n = n_seen[c];
      row.report_chan = c[2:0];
      row.total_samples = n[19:0];
      row.over_hits = n_over[c][19:0];
      row.under_hits = n_under[c][19:0];
      row.fault_hits = n_fault[c][19:0];
      row.range_hits = n_range[c][19:0];
      row.last_row = (c == CHANNELS - 1);
      if (n != 0) begin
        s = code_total[c];
        s2 = square_total[c];
        q = s / n;
        r = s % n;
        row.mean_value = clip16(div_shift(s, n, 4));
        row.min_value = code_low[c][11:0];
        row.max_value = code_high[c][11:0];
        row.rms_value = clip16(int_root(div_shift(s2, n, 8)));
        a = (s2 > q * q * n) ? s2 - q * q * n : 0;
        a = (a > 2 * q * r) ? a - 2 * q * r : 0;
        v = div_shift(a, n, 8);
        f = (r << 16) / n;
        frac = (f * f) >> 24;
        v = (v > frac) ? v - frac : 0;
        row.std_value = clip16(int_root(v));
      end
      pending_rows.push_back(row);
    end
    clear_shadow();
  endtask

  // Called just after a rising edge; returns just after the edge that takes the beat.
  task automatic send_beat(in_beat_t b);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    predict_beat(b);
  endtask

  task automatic pause_input(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic in_beat_t sample_beat(int ch, int code, bit flt, bit rng);
    in_beat_t b;
    b.req_type = REQ_SAMPLE;
    b.chan_id = ch[7:0];
    b.sample_code = code[11:0];
    b.sensor_fault = flt;
    b.range_flag = rng;
    return b;
  endfunction

  function automatic in_beat_t report_beat();
    in_beat_t b;
    b = in_beat_t'($urandom);
    b.req_type = REQ_REPORT;
    return b;
  endfunction

  // Waits for every row, then lets any sample still in flight settle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val[THR_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OVER) over_lim = val & 12'hFFF;
    else under_lim = val & 12'hFFF;
  endtask

  // Long receiver hold-off, started by a test and timed here.
  always begin
    @(hold_ev);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Receiver: stall pattern of its own, plus the long hold-off when asked.
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (out_valid && out_ready && rst_n) begin
      rows_seen++;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row %p", out_data);
      end else begin
        out_beat_t want;
        want = pending_rows.pop_front();
        if (want.report_chan !== out_data.report_chan ||
            want.total_samples !== out_data.total_samples ||
            want.over_hits !== out_data.over_hits ||
            want.under_hits !== out_data.under_hits ||
            want.fault_hits !== out_data.fault_hits ||
            want.range_hits !== out_data.range_hits ||
            want.mean_value !== out_data.mean_value ||
            want.min_value !== out_data.min_value ||
            want.max_value !== out_data.max_value ||
            want.rms_value !== out_data.rms_value ||
            want.std_value !== out_data.std_value ||
            want.last_row !== out_data.last_row) begin
          mismatches++;
          if (mismatches <= 10) $display("row mismatch: expected %p got %p", want, out_data);
        end
      end
    end
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic test_empty_report();
    send_beat(report_beat());
    send_beat(report_beat());
    settle();
  endtask

  task automatic test_field_extremes();
    send_beat(sample_beat(0, 0, 1'b0, 1'b0));
    send_beat(sample_beat(0, 4095, 1'b1, 1'b1));
    send_beat(sample_beat(7, 4095, 1'b1, 1'b0));
    send_beat(sample_beat(7, 4095, 1'b0, 1'b1));
    send_beat(sample_beat(3, 1, 1'b0, 1'b0));
    send_beat(sample_beat(3, 2, 1'b0, 1'b0));
    send_beat(sample_beat(3, 2, 1'b0, 1'b0));
    send_beat(sample_beat(8, 1234, 1'b1, 1'b1));
    send_beat(sample_beat(255, 2730, 1'b1, 1'b1));
    send_beat(sample_beat(170, 1365, 1'b0, 1'b0));
    send_beat(report_beat());
    settle();
  endtask

  task automatic test_thresholds(int unsigned over_v, int unsigned under_v);
    write_reg(CFG_OVER, over_v);
    write_reg(CFG_UNDER, under_v);
    for (int k = 0; k < 12; k++)
      send_beat(sample_beat($urandom_range(0, CHANNELS - 1),
                            (k < 2) ? k * 4095 : $urandom_range(0, 4095),
                            $urandom_range(0, 1), $urandom_range(0, 1)));
    send_beat(report_beat());
    settle();
  endtask

  // Runs of samples with reports and stray channels mixed in, closed by a final report.
  task automatic test_random_traffic(int unsigned items);
    int unsigned sent, burst, pick;
    in_beat_t b;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < items; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) b = report_beat();
        else if (pick < 14) b = sample_beat($urandom_range(CHANNELS, 255), $urandom,
                                            $urandom, $urandom);
        else begin
          b = sample_beat($urandom_range(0, CHANNELS - 1), $urandom, $urandom, $urandom);
          if ($urandom_range(0, 4) == 0) b.sample_code = 12'($urandom_range(2040, 2056));
        end
        send_beat(b);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 12));
    end
    send_beat(report_beat());
    settle();
  endtask

  task automatic test_backpressure();
    -> hold_ev;
    for (int k = 0; k < 6; k++)
      send_beat(sample_beat(k, $urandom, 1'b0, 1'b1));
    send_beat(report_beat());
    for (int k = 0; k < 10; k++)
      send_beat(sample_beat($urandom_range(0, CHANNELS - 1), $urandom, 1'b1, 1'b0));
    send_beat(report_beat());
    settle();
  endtask

  initial begin
    clear_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_report();
    test_field_extremes();
    test_thresholds(0, 4095);
    test_thresholds(2048, 2048);
    test_thresholds(4095, 0);
    test_thresholds($urandom_range(0, 4095), $urandom_range(0, 4095));
    test_backpressure();
    write_reg(CFG_OVER, 3000);
    write_reg(CFG_UNDER, 1000);
    test_random_traffic(100);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pcss_pkg.sv
hdl/pcss_div.sv
hdl/pcss_sqrt.sv
hdl/pcss_store.sv
hdl/pcss_stats.sv
hdl/per_channel_sample_statistics_top.sv
hdl/pcss_checker.sv
tb/testbench.sv
